/* rtl/core/gram_pkg.sv */
// ----------------------------------------------------------------------------
// gram_pkg
// Shared types and constants for the gain ramp mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package gram_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 16;
  localparam int ACC_BITS    = 32;
  localparam int CFG_BITS    = 32;
  localparam int LEN_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  // src * gain, gain zero-extended to signed
  localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int FRAC_SHIFT  = GAIN_BITS - 2;
  localparam int SCALED_BITS = PROD_BITS - FRAC_SHIFT;
  localparam int SUM_BITS    = SCALED_BITS + 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GAIN_START   = 2'd0,
    CFG_GAIN_STEP    = 2'd1,
    CFG_BLOCK_LENGTH = 2'd2
  } cfg_reg_t;

  localparam logic [GAIN_BITS-1:0] GAIN_START_RST   = GAIN_BITS'(16384);
  localparam logic [ACC_BITS-1:0]  GAIN_STEP_RST    = '0;
  localparam logic [LEN_BITS-1:0]  BLOCK_LENGTH_RST = LEN_BITS'(256);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] src_sample;
    logic signed [SAMPLE_BITS-1:0] mix_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mixed_sample;
    logic                          clipped;
  } out_item_t;

  // Pipeline occupancy, reported to the top level
  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } pipe_status_t;

endpackage

`default_nettype wire

/* rtl/core/gain_ramp_mixer_unit.sv */
// ----------------------------------------------------------------------------
// gain_ramp_mixer_unit
// Mixes a gain-scaled source sample into a mix sample with a linear gain ramp.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low and returns mix +
// round(src * gain), saturated to 24 bits, on out_: the item sits in an
// input register, and the 24x17 multiply, rounding and saturating add in
// front of the result register set the clock rate. Gain is Q2.14 taken from
// a 32-bit Q2.30 accumulator that starts at gain_start, moves by gain_step
// per item and reloads every block_length items. A write to a defined register
// restarts the ramp; write registers only while the pipeline is empty.
`default_nettype none

module gain_ramp_mixer_unit
  import gram_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire in_item_t                in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output out_item_t                    out_data,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_wdata
);

  logic                 in_accept;
  logic [GAIN_BITS-1:0] gain;
  pipe_status_t         status;

  assign in_accept = in_valid && !in_stall;

  gram_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (in_accept),
    .gain      (gain)
  );

  gram_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .gain      (gain),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (status)
  );

  // Input only backs up when both registers are full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (status.s1_valid && status.s2_valid && out_stall))
    else $error("input stalled with room in pipeline");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clipped) |->
      (out_data.mixed_sample == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
       out_data.mixed_sample == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
    else $error("clip flag without saturated sample");

  a_start_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == CFG_GAIN_START) |=> (gain == $past(cfg_wdata[GAIN_BITS-1:0])))
    else $error("gain not reloaded from gain_start");

endmodule

`default_nettype wire

/* rtl/core/gram_ramp.sv */
// ----------------------------------------------------------------------------
// gram_ramp
// Configuration registers, gain accumulator and block sample counter.
// ----------------------------------------------------------------------------
`default_nettype none

module gram_ramp
  import gram_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_wdata,
  input  wire logic                    advance,
  output logic      [GAIN_BITS-1:0]    gain
);

  logic [GAIN_BITS-1:0] gain_start_r, gain_start_nxt;
  logic [ACC_BITS-1:0]  gain_step_r, gain_step_nxt;
  logic [LEN_BITS-1:0]  block_length_r, block_length_nxt;
  logic [ACC_BITS-1:0]  acc_r, acc_nxt;
  logic [LEN_BITS-1:0]  idx_r, idx_nxt;
  logic                 cfg_hit;
  logic signed [ACC_BITS+1:0] acc_sum;
  logic [ACC_BITS-1:0]  acc_sat;
  logic [LEN_BITS-1:0]  idx_inc;

  always_comb begin
    gain_start_nxt   = gain_start_r;
    gain_step_nxt    = gain_step_r;
    block_length_nxt = block_length_r;
    cfg_hit          = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GAIN_START: begin
          gain_start_nxt = cfg_wdata[GAIN_BITS-1:0];
          cfg_hit        = 1'b1;
        end
        CFG_GAIN_STEP: begin
          gain_step_nxt = cfg_wdata[ACC_BITS-1:0];
          cfg_hit       = 1'b1;
        end
        CFG_BLOCK_LENGTH: begin
          block_length_nxt = cfg_wdata[LEN_BITS-1:0];
          cfg_hit          = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Ramp step saturates to the unsigned accumulator range
  always_comb begin
    acc_sum = $signed({2'b00, acc_r}) + $signed({{2{gain_step_r[ACC_BITS-1]}}, gain_step_r});
    if (acc_sum[ACC_BITS+1]) begin
      acc_sat = '0;
    end else if (acc_sum[ACC_BITS]) begin
      acc_sat = '1;
    end else begin
      acc_sat = acc_sum[ACC_BITS-1:0];
    end
    idx_inc = idx_r + LEN_BITS'(1);
  end

  // Zero block length falls out as 65536 via index wrap
  always_comb begin
    acc_nxt = acc_r;
    idx_nxt = idx_r;
    if (cfg_hit) begin
      acc_nxt = {gain_start_nxt, {(ACC_BITS-GAIN_BITS){1'b0}}};
      idx_nxt = '0;
    end else if (advance) begin
      if (idx_inc == block_length_r) begin
        acc_nxt = {gain_start_r, {(ACC_BITS-GAIN_BITS){1'b0}}};
        idx_nxt = '0;
      end else begin
        acc_nxt = acc_sat;
        idx_nxt = idx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_start_r   <= GAIN_START_RST;
      gain_step_r    <= GAIN_STEP_RST;
      block_length_r <= BLOCK_LENGTH_RST;
      acc_r          <= {GAIN_START_RST, {(ACC_BITS-GAIN_BITS){1'b0}}};
      idx_r          <= '0;
    end else begin
      gain_start_r   <= gain_start_nxt;
      gain_step_r    <= gain_step_nxt;
      block_length_r <= block_length_nxt;
      acc_r          <= acc_nxt;
      idx_r          <= idx_nxt;
    end
  end

  assign gain = acc_r[ACC_BITS-1 -: GAIN_BITS];

endmodule

`default_nettype wire

/* rtl/core/gram_datapath.sv */
// ----------------------------------------------------------------------------
// gram_datapath
// Input register, then scale, round, add and saturate into the result
// register, with per-stage flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module gram_datapath
  import gram_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  input  wire logic [GAIN_BITS-1:0] gain,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  output pipe_status_t              status
);

  localparam logic signed [PROD_BITS-1:0] ROUND_BIAS = PROD_BITS'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [SUM_BITS-1:0]  SAT_HI =
    SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_BITS-1:0]  SAT_LO = -SAT_HI - SUM_BITS'(1);

  logic en1, en2;
  logic s1_valid_r, s2_valid_r;

  logic signed [SAMPLE_BITS-1:0] s1_src_r, s1_mix_r;
  logic        [GAIN_BITS-1:0]   s1_gain_r;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [SCALED_BITS-1:0] scaled;
  logic signed [SUM_BITS-1:0]    sum;
  out_item_t                     s2_nxt, s2_r;

  // A stage loads when it is empty or its contents move on
  assign en2      = !s2_valid_r || !out_stall;
  assign en1      = !s1_valid_r || en2;
  assign in_stall = !en1;

  always_comb begin
    prod   = s1_src_r * $signed({1'b0, s1_gain_r});
    prod   = prod + ROUND_BIAS;
    scaled = prod[PROD_BITS-1:FRAC_SHIFT];
    sum    = $signed({{(SUM_BITS-SAMPLE_BITS){s1_mix_r[SAMPLE_BITS-1]}}, s1_mix_r})
           + $signed({scaled[SCALED_BITS-1], scaled});
    if (sum > SAT_HI) begin
      s2_nxt.mixed_sample = SAT_HI[SAMPLE_BITS-1:0];
      s2_nxt.clipped      = 1'b1;
    end else if (sum < SAT_LO) begin
      s2_nxt.mixed_sample = SAT_LO[SAMPLE_BITS-1:0];
      s2_nxt.clipped      = 1'b1;
    end else begin
      s2_nxt.mixed_sample = sum[SAMPLE_BITS-1:0];
      s2_nxt.clipped      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r <= in_valid;
      if (en2) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_src_r  <= in_data.src_sample;
      s1_mix_r  <= in_data.mix_sample;
      s1_gain_r <= gain;
    end
    if (en2) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_r;
  assign status    = '{s1_valid: s1_valid_r, s2_valid: s2_valid_r};

endmodule

`default_nettype wire
